/* rtl/ncs_pkg.sv */
// ----------------------------------------------------------------------------
// ncs_pkg
// Types, constants and the bus-cycle sequence table for the NAND command
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ncs_pkg;

    localparam int ADDR_W          = 25;
    localparam int PAGE_BYTES_DEF  = 512;
    localparam int BLOCK_BYTES_DEF = 16384;
    localparam int JOBQ_DEPTH      = 2;

    localparam logic [15:0] SIG_RESET = 16'h7520;

    localparam logic [7:0] CMD_READ_SETUP    = 8'h00;
    localparam logic [7:0] CMD_READ_SPARE    = 8'h50;
    localparam logic [7:0] CMD_READ_ID       = 8'h90;
    localparam logic [7:0] CMD_READ_STATUS   = 8'h70;
    localparam logic [7:0] CMD_PROGRAM       = 8'h80;
    localparam logic [7:0] CMD_PROG_CONFIRM  = 8'h10;
    localparam logic [7:0] CMD_ERASE         = 8'h60;
    localparam logic [7:0] CMD_ERASE_CONFIRM = 8'hD0;
    localparam logic [7:0] CMD_RESET         = 8'hFF;

    localparam logic [7:0] STATUS_FAIL_MASK = 8'h01;
    localparam logic [7:0] GOOD_BLOCK_MARK  = 8'hFF;
    localparam logic [7:0] SPARE_MARK_COL   = 8'd6;

    typedef enum logic [3:0] {
        MODE_START_READ  = 4'd0,
        MODE_READ_WORD   = 4'd1,
        MODE_START_WRITE = 4'd2,
        MODE_WRITE_WORD  = 4'd3,
        MODE_ERASE       = 4'd4,
        MODE_BAD_CHECK   = 4'd5,
        MODE_SIGNATURE   = 4'd6,
        MODE_STATUS      = 4'd7,
        MODE_RESET       = 4'd8,
        MODE_JUDGE       = 4'd9
    } mode_t;

    typedef enum logic [2:0] {
        PEND_NONE  = 3'd0,
        PEND_READ  = 3'd1,
        PEND_WRITE = 3'd2,
        PEND_PROG  = 3'd3,
        PEND_ERASE = 3'd4,
        PEND_BAD   = 3'd5,
        PEND_SIG   = 3'd6
    } pend_t;

    typedef enum logic [2:0] {
        KIND_CMD     = 3'd0,
        KIND_ADDR    = 3'd1,
        KIND_W32     = 3'd2,
        KIND_R32     = 3'd3,
        KIND_R8      = 3'd4,
        KIND_R16     = 3'd5,
        KIND_WAIT    = 3'd6,
        KIND_VERDICT = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        OUT_OK         = 3'd0,
        OUT_WRITE_ERR  = 3'd1,
        OUT_BAD_DEVICE = 3'd2,
        OUT_BAD_BLOCK  = 3'd3,
        OUT_NONE       = 3'd4
    } outcome_t;

    typedef enum logic [2:0] {
        SRC_ZERO   = 3'd0,
        SRC_CMD    = 3'd1,
        SRC_COL    = 3'd2,
        SRC_ROW_LO = 3'd3,
        SRC_ROW_HI = 3'd4,
        SRC_WDATA  = 3'd5
    } src_t;

    typedef struct packed {
        logic [3:0]        mode;
        logic [ADDR_W-1:0] flash_address;
        logic [31:0]       write_data;
        logic              final_word;
        logic [15:0]       chip_reply;
    } req_t;

    typedef struct packed {
        logic [2:0]  cycle_kind;
        logic [31:0] bus_value;
        logic        chip_select;
        logic        program_allowed;
        logic [2:0]  outcome;
        logic        run_end;
    } rsp_t;

    // data: write word, or {-, row hi, row lo, column} address bytes
    typedef struct packed {
        mode_t       op;
        logic        fin;
        logic [31:0] data;
        logic        sel;
        logic        prot;
        outcome_t    verdict;
    } job_t;

    typedef struct packed {
        kind_t      kind;
        src_t       src;
        logic [7:0] cmd;
        logic       last;
    } step_t;

    function automatic step_t mk_step(kind_t k, src_t s, logic [7:0] c, logic l);
        step_t r;
        r.kind = k;
        r.src  = s;
        r.cmd  = c;
        r.last = l;
        return r;
    endfunction

    function automatic step_t seq_step(mode_t op, logic fin, logic [2:0] idx);
        step_t r;
        r = mk_step(KIND_WAIT, SRC_ZERO, CMD_READ_SETUP, 1'b1);
        case (op)
            MODE_START_READ:
            begin
                case (idx)
                    3'd0: r = mk_step(KIND_WAIT, SRC_ZERO, CMD_READ_SETUP, 1'b0);
                    3'd1: r = mk_step(KIND_CMD, SRC_CMD, CMD_READ_SETUP, 1'b0);
                    3'd2: r = mk_step(KIND_ADDR, SRC_COL, CMD_READ_SETUP, 1'b0);
                    3'd3: r = mk_step(KIND_ADDR, SRC_ROW_LO, CMD_READ_SETUP, 1'b0);
                    3'd4: r = mk_step(KIND_ADDR, SRC_ROW_HI, CMD_READ_SETUP, 1'b0);
                    default: r = mk_step(KIND_WAIT, SRC_ZERO, CMD_READ_SETUP, 1'b1);
                endcase
            end
            MODE_READ_WORD:
                r = mk_step(KIND_R32, SRC_ZERO, CMD_READ_SETUP, 1'b1);
            MODE_START_WRITE:
            begin
                case (idx)
                    3'd0: r = mk_step(KIND_CMD, SRC_CMD, CMD_READ_SETUP, 1'b0);
                    3'd1: r = mk_step(KIND_CMD, SRC_CMD, CMD_PROGRAM, 1'b0);
                    3'd2: r = mk_step(KIND_ADDR, SRC_COL, CMD_READ_SETUP, 1'b0);
                    3'd3: r = mk_step(KIND_ADDR, SRC_ROW_LO, CMD_READ_SETUP, 1'b0);
                    3'd4: r = mk_step(KIND_ADDR, SRC_ROW_HI, CMD_READ_SETUP, 1'b0);
                    default: r = mk_step(KIND_WAIT, SRC_ZERO, CMD_READ_SETUP, 1'b1);
                endcase
            end
            MODE_WRITE_WORD:
            begin
                case (idx)
                    3'd0: r = mk_step(KIND_W32, SRC_WDATA, CMD_READ_SETUP, !fin);
                    3'd1: r = mk_step(KIND_CMD, SRC_CMD, CMD_PROG_CONFIRM, 1'b0);
                    3'd2: r = mk_step(KIND_WAIT, SRC_ZERO, CMD_READ_SETUP, 1'b0);
                    3'd3: r = mk_step(KIND_CMD, SRC_CMD, CMD_READ_STATUS, 1'b0);
                    default: r = mk_step(KIND_R8, SRC_ZERO, CMD_READ_SETUP, 1'b1);
                endcase
            end
            MODE_ERASE:
            begin
                case (idx)
                    3'd0: r = mk_step(KIND_CMD, SRC_CMD, CMD_ERASE, 1'b0);
                    3'd1: r = mk_step(KIND_ADDR, SRC_ROW_LO, CMD_READ_SETUP, 1'b0);
                    3'd2: r = mk_step(KIND_ADDR, SRC_ROW_HI, CMD_READ_SETUP, 1'b0);
                    3'd3: r = mk_step(KIND_CMD, SRC_CMD, CMD_ERASE_CONFIRM, 1'b0);
                    3'd4: r = mk_step(KIND_WAIT, SRC_ZERO, CMD_READ_SETUP, 1'b0);
                    3'd5: r = mk_step(KIND_CMD, SRC_CMD, CMD_READ_STATUS, 1'b0);
                    default: r = mk_step(KIND_R8, SRC_ZERO, CMD_READ_SETUP, 1'b1);
                endcase
            end
            MODE_BAD_CHECK:
            begin
                case (idx)
                    3'd0: r = mk_step(KIND_WAIT, SRC_ZERO, CMD_READ_SETUP, 1'b0);
                    3'd1: r = mk_step(KIND_CMD, SRC_CMD, CMD_READ_SPARE, 1'b0);
                    3'd2: r = mk_step(KIND_ADDR, SRC_COL, CMD_READ_SETUP, 1'b0);
                    3'd3: r = mk_step(KIND_ADDR, SRC_ROW_LO, CMD_READ_SETUP, 1'b0);
                    3'd4: r = mk_step(KIND_ADDR, SRC_ROW_HI, CMD_READ_SETUP, 1'b0);
                    3'd5: r = mk_step(KIND_WAIT, SRC_ZERO, CMD_READ_SETUP, 1'b0);
                    default: r = mk_step(KIND_R8, SRC_ZERO, CMD_READ_SETUP, 1'b1);
                endcase
            end
            MODE_SIGNATURE:
            begin
                case (idx)
                    3'd0: r = mk_step(KIND_CMD, SRC_CMD, CMD_READ_ID, 1'b0);
                    default: r = mk_step(KIND_R16, SRC_ZERO, CMD_READ_SETUP, 1'b1);
                endcase
            end
            MODE_STATUS:
            begin
                case (idx)
                    3'd0: r = mk_step(KIND_CMD, SRC_CMD, CMD_READ_STATUS, 1'b0);
                    default: r = mk_step(KIND_R8, SRC_ZERO, CMD_READ_SETUP, 1'b1);
                endcase
            end
            MODE_RESET:
            begin
                case (idx)
                    3'd0: r = mk_step(KIND_WAIT, SRC_ZERO, CMD_READ_SETUP, 1'b0);
                    3'd1: r = mk_step(KIND_CMD, SRC_CMD, CMD_RESET, 1'b0);
                    default: r = mk_step(KIND_WAIT, SRC_ZERO, CMD_READ_SETUP, 1'b1);
                endcase
            end
            MODE_JUDGE:
                r = mk_step(KIND_VERDICT, SRC_ZERO, CMD_READ_SETUP, 1'b1);
            default:
                r = mk_step(KIND_WAIT, SRC_ZERO, CMD_READ_SETUP, 1'b1);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/ncs_front.sv */
// ----------------------------------------------------------------------------
// ncs_front
// Request decode: tracks the pending operation and chip enable / write
// protect, forms address bytes and judges replies, then queues one job.
// ----------------------------------------------------------------------------
`default_nettype none

module ncs_front #(
    parameter int PAGE_BYTES  = ncs_pkg::PAGE_BYTES_DEF,
    parameter int BLOCK_BYTES = ncs_pkg::BLOCK_BYTES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ncs_pkg::req_t request,
    input  wire logic [15:0]   expected_sig,
    input  wire logic          jobq_full,
    output logic               job_push,
    output ncs_pkg::job_t      job
);
    import ncs_pkg::*;

    localparam logic [31:0] PAGE_MASK  = ~(32'(PAGE_BYTES) - 32'd1);
    localparam logic [31:0] BLOCK_MASK = ~(32'(BLOCK_BYTES) - 32'd1);

    pend_t pend_reg, pend_next;
    logic  sel_reg, sel_next;
    logic  prot_reg, prot_next;

    logic        accept;
    logic        known;
    logic [31:0] addr32;
    logic [31:0] page_a;
    logic [31:0] block_a;
    outcome_t    verdict;

    assign accept  = push && !jobq_full;
    assign addr32  = {{(32-ADDR_W){1'b0}}, request.flash_address};
    assign page_a  = addr32 & PAGE_MASK;
    assign block_a = addr32 & BLOCK_MASK;

    always_comb
    begin
        case (pend_reg)
            PEND_PROG,
            PEND_ERASE:
                verdict = ((request.chip_reply[7:0] & STATUS_FAIL_MASK) != 8'd0)
                          ? OUT_WRITE_ERR : OUT_OK;
            PEND_BAD:
                verdict = (request.chip_reply[7:0] != GOOD_BLOCK_MARK)
                          ? OUT_BAD_BLOCK : OUT_OK;
            PEND_SIG:
                verdict = (request.chip_reply != expected_sig) ? OUT_BAD_DEVICE : OUT_OK;
            default:
                verdict = OUT_NONE;
        endcase
    end

    always_comb
    begin
        pend_next   = pend_reg;
        sel_next    = sel_reg;
        prot_next   = prot_reg;
        known       = 1'b1;
        job.op      = mode_t'(request.mode);
        job.fin     = request.final_word;
        job.data    = 32'd0;
        job.sel     = sel_reg;
        job.prot    = prot_reg;
        job.verdict = verdict;
        case (mode_t'(request.mode))
            MODE_START_READ:
            begin
                sel_next  = 1'b1;
                pend_next = PEND_READ;
                job.sel   = 1'b1;
                job.data  = {8'd0, page_a[24:17], page_a[16:9], page_a[7:0]};
            end
            MODE_READ_WORD:
            begin
                if (request.final_word)
                begin
                    sel_next = 1'b0;
                    if (pend_reg == PEND_READ)
                        pend_next = PEND_NONE;
                end
            end
            MODE_START_WRITE:
            begin
                sel_next  = 1'b1;
                prot_next = 1'b1;
                pend_next = PEND_WRITE;
                job.sel   = 1'b1;
                job.prot  = 1'b1;
                job.data  = {8'd0, page_a[24:17], page_a[16:9], page_a[7:0]};
            end
            MODE_WRITE_WORD:
            begin
                job.data = request.write_data;
                if (request.final_word)
                    pend_next = PEND_PROG;
            end
            MODE_ERASE:
            begin
                sel_next  = 1'b1;
                prot_next = 1'b1;
                pend_next = PEND_ERASE;
                job.sel   = 1'b1;
                job.prot  = 1'b1;
                job.data  = {8'd0, block_a[24:17], block_a[16:9], 8'd0};
            end
            MODE_BAD_CHECK:
            begin
                sel_next  = 1'b1;
                pend_next = PEND_BAD;
                job.sel   = 1'b1;
                job.data  = {8'd0, page_a[24:17], page_a[16:9],
                             page_a[7:0] + SPARE_MARK_COL};
            end
            MODE_SIGNATURE:
            begin
                sel_next  = 1'b1;
                pend_next = PEND_SIG;
                job.sel   = 1'b1;
            end
            MODE_STATUS:
            begin
                known = 1'b1;
            end
            MODE_RESET:
            begin
                sel_next  = 1'b0;
                pend_next = PEND_NONE;
                job.sel   = 1'b1;
            end
            MODE_JUDGE:
            begin
                sel_next  = 1'b0;
                prot_next = 1'b0;
                pend_next = PEND_NONE;
                job.sel   = 1'b0;
                job.prot  = 1'b0;
            end
            default:
            begin
                known     = 1'b0;
                job.op    = MODE_JUDGE;
            end
        endcase
    end

    assign job_push = accept && known;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= PEND_NONE;
            sel_reg  <= 1'b0;
            prot_reg <= 1'b0;
        end
        else if (accept && known)
        begin
            pend_reg <= pend_next;
            sel_reg  <= sel_next;
            prot_reg <= prot_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/ncs_jobq.sv */
// ----------------------------------------------------------------------------
// ncs_jobq
// Short job queue between request decode and the bus-cycle sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ncs_jobq #(
    parameter int DEPTH = ncs_pkg::JOBQ_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire ncs_pkg::job_t wr_job,
    input  wire logic          rd_en,
    output ncs_pkg::job_t      rd_job,
    output logic               full,
    output logic               empty
);
    import ncs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full   = (count_reg == CNT_FULL);
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

`default_nettype wire

/* rtl/ncs_back.sv */
// ----------------------------------------------------------------------------
// ncs_back
// Bus-cycle sequencer: steps through the cycle list of each job, one word
// per clock into a result register, stalling while that register is held unpopped.
// ----------------------------------------------------------------------------
`default_nettype none

module ncs_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          jobq_empty,
    input  wire ncs_pkg::job_t jobq_job,
    output logic               jobq_pop,
    input  wire logic          pop,
    output logic               empty,
    output ncs_pkg::rsp_t      result
);
    import ncs_pkg::*;

    logic       cur_valid_reg, cur_valid_next;
    job_t       cur_reg, cur_next;
    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    rsp_t       out_reg, out_next;

    step_t      st;
    logic       out_free;
    logic       adv;
    logic       take;
    rsp_t       rsp;

    assign st       = seq_step(cur_reg.op, cur_reg.fin, idx_reg);
    assign out_free = !out_valid_reg || pop;
    assign adv      = cur_valid_reg && out_free;
    assign take     = !jobq_empty && (!cur_valid_reg || (adv && st.last));
    assign jobq_pop = take;

    always_comb
    begin
        rsp.cycle_kind      = st.kind;
        rsp.chip_select     = cur_reg.sel;
        rsp.program_allowed = cur_reg.prot;
        rsp.outcome         = (st.kind == KIND_VERDICT) ? cur_reg.verdict : OUT_NONE;
        rsp.run_end         = st.last;
        case (st.src)
            SRC_CMD:    rsp.bus_value = {24'd0, st.cmd};
            SRC_COL:    rsp.bus_value = {24'd0, cur_reg.data[7:0]};
            SRC_ROW_LO: rsp.bus_value = {24'd0, cur_reg.data[15:8]};
            SRC_ROW_HI: rsp.bus_value = {24'd0, cur_reg.data[23:16]};
            SRC_WDATA:  rsp.bus_value = cur_reg.data;
            default:    rsp.bus_value = 32'd0;
        endcase
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (take)
        begin
            cur_valid_next = 1'b1;
            cur_next       = jobq_job;
            idx_next       = 3'd0;
        end
        else if (adv && st.last)
            cur_valid_next = 1'b0;
        else if (adv)
            idx_next = idx_reg + 3'd1;
        if (adv)
        begin
            out_valid_next = 1'b1;
            out_next       = rsp;
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

`default_nettype wire

/* rtl/nand_flash_command_sequencer.sv */
// ----------------------------------------------------------------------------
// nand_flash_command_sequencer
// Turns flash requests into small-page NAND bus cycles and verdicts.
//
//   channel   direction  handshake             word
//   request   in         push / full           req_t
//   result    out        pop / empty           rsp_t
//   config    in         APB psel/penable      expected signature at 0x0
//
// The sequencer emits one bus cycle per clock while the result register is
// free; the bus cycles of an item are set by its cycle list in the back end.
// Decode accepts one item per clock while the job queue has room.
// A stalled pop holds the result register; the job queue then fills and
// full rises. Reset clears pending state, selects and both queues.
// ----------------------------------------------------------------------------
`default_nettype none

module nand_flash_command_sequencer #(
    parameter int PAGE_BYTES  = ncs_pkg::PAGE_BYTES_DEF,
    parameter int BLOCK_BYTES = ncs_pkg::BLOCK_BYTES_DEF,
    parameter int JOB_DEPTH   = ncs_pkg::JOBQ_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire ncs_pkg::req_t request,
    input  wire logic          pop,
    output logic               empty,
    output ncs_pkg::rsp_t      result,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ncs_pkg::*;

    logic [15:0] sig_reg;
    logic        cfg_wr;
    logic        jobq_full;
    logic        jobq_empty;
    logic        job_push;
    logic        jobq_pop;
    job_t        job_in;
    job_t        job_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, sig_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sig_reg <= SIG_RESET;
        else if (cfg_wr && (paddr[2] == 1'b0))
            sig_reg <= pwdata[15:0];
    end

    assign full = jobq_full;

    ncs_front #(
        .PAGE_BYTES  (PAGE_BYTES),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .request      (request),
        .expected_sig (sig_reg),
        .jobq_full    (jobq_full),
        .job_push     (job_push),
        .job          (job_in)
    );

    ncs_jobq #(
        .DEPTH (JOB_DEPTH)
    ) u_jobq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (job_in),
        .rd_en  (jobq_pop),
        .rd_job (job_out),
        .full   (jobq_full),
        .empty  (jobq_empty)
    );

    ncs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .jobq_empty (jobq_empty),
        .jobq_job   (job_out),
        .jobq_pop   (jobq_pop),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule

`default_nettype wire

/* rtl/ncs_checker.sv */
// ----------------------------------------------------------------------------
// ncs_checker
// Port-level checks on the result channel of the command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ncs_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          pop,
    input wire logic          empty,
    input wire ncs_pkg::rsp_t result
);
    import ncs_pkg::*;

    // held word stays put until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.cycle_kind != KIND_VERDICT)) |-> (result.outcome == OUT_NONE))
        else $error("outcome on a bus cycle");

    // verdict ends its run with chip enable and write enable dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.cycle_kind == KIND_VERDICT))
            |-> (result.run_end && !result.chip_select && !result.program_allowed))
        else $error("verdict word malformed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && ((result.cycle_kind == KIND_CMD) || (result.cycle_kind == KIND_ADDR)))
            |-> (result.bus_value[31:8] == 24'd0))
        else $error("command or address byte too wide");

endmodule

bind nand_flash_command_sequencer ncs_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);

`default_nettype wire
